/* hw/rtl/quaternion_normalizer_macros.svh */
// assertion helpers for the quaternion normaliser
`ifndef QUATERNION_NORMALIZER_MACROS_SVH
`define QUATERNION_NORMALIZER_MACROS_SVH
`ifndef SYNTHESIS
`define QN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qnorm check failed");
`define QN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qnorm check failed");
`else
`define QN_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define QN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/qnorm_pkg.sv */
package qnorm_pkg;

    // default component width and the count of quaternion components
    localparam int COMP_WIDTH_DEF = 16;
    localparam int N_COMPS        = 4;

endpackage

/* hw/rtl/quaternion_normalizer.sv */
// quaternion normaliser
// input channel: comp_w/x/y/z (signed Q2.F, F = COMP_WIDTH-3) with in_valid and
// in_stall; a transfer happens on a clock edge with in_valid high and in_stall low.
// output channel: unit_w/x/y/z (signed Q1.F), magnitude (unsigned, saturated)
// and zero_length, with out_valid and out_stall.
// one quaternion is taken every cycle while the output is not stalled; there is
// no dependence between items.
// from input transfer to out_valid the data passes 2*COMP_WIDTH + 3 register
// stages, the first of which loads at the transfer edge: square lanes 1, sum 1,
// square root COMP_WIDTH + 2 (one root bit per stage plus rounding), divider
// lanes COMP_WIDTH - 2 (one quotient bit per stage), output register 1.
// a zero-length input yields zero components, magnitude 0 and zero_length set.
// when out_valid is high and out_stall is high, the whole pipeline freezes and
// in_stall is raised in the same cycle; the result register holds its value.
// reset (rst_n low, asynchronous) empties the pipeline; no result is pending.
module quaternion_normalizer #(
    parameter int COMP_WIDTH = qnorm_pkg::COMP_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COMP_WIDTH-1:0] comp_w,
    input  logic signed [COMP_WIDTH-1:0] comp_x,
    input  logic signed [COMP_WIDTH-1:0] comp_y,
    input  logic signed [COMP_WIDTH-1:0] comp_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COMP_WIDTH-2:0] unit_w,
    output logic signed [COMP_WIDTH-2:0] unit_x,
    output logic signed [COMP_WIDTH-2:0] unit_y,
    output logic signed [COMP_WIDTH-2:0] unit_z,
    output logic [COMP_WIDTH-1:0]        magnitude,
    output logic                         zero_length
);

    `include "quaternion_normalizer_macros.svh"

    localparam int W      = COMP_WIDTH;
    localparam int F      = W - 3;
    localparam int NC     = qnorm_pkg::N_COMPS;
    localparam int SIDE_W = NC * (W + 1);

    logic adv;

    logic signed [W-1:0] comp_arr [NC];
    logic [W-1:0]        mag_s1   [NC];
    logic                neg_s1   [NC];
    logic [2*W-2:0]      sq_s1    [NC];
    logic                vld_s1_reg;

    logic [2*W:0]      sum_next;
    logic [2*W:0]      sum_reg;
    logic [SIDE_W-1:0] side_next;
    logic [SIDE_W-1:0] side_reg;
    logic              vld_s2_reg;

    logic              sq_vld;
    logic [W:0]        len_sq;
    logic [SIDE_W-1:0] side_sq;

    logic                dv_vld [NC];
    logic signed [W-2:0] dv_unit [NC];
    logic [W:0]          dv_len  [NC];

    logic                out_valid_reg;
    logic signed [W-2:0] unit_reg [NC];
    logic [W-1:0]        mag_reg;
    logic                zero_reg;
    logic                zero_next;

    // pipeline moves unless a finished result is held by the receiver
    assign in_stall = out_valid_reg & out_stall;
    assign adv      = ~in_stall;

    assign comp_arr[0] = comp_w;
    assign comp_arr[1] = comp_x;
    assign comp_arr[2] = comp_y;
    assign comp_arr[3] = comp_z;

    // square lanes
    genvar i;
    generate
        for (i = 0; i < NC; i++)
        begin : g_sq
            qnorm_square #(.W(W)) u_square (
                .clk  (clk),
                .en   (adv),
                .comp (comp_arr[i]),
                .mag  (mag_s1[i]),
                .neg  (neg_s1[i]),
                .sq   (sq_s1[i])
            );
            assign side_next[i*(W+1) +: W+1] = {neg_s1[i], mag_s1[i]};
        end
    endgenerate

    // merge: exact sum of the four squares
    always_comb
    begin
        sum_next = (2*W+1)'(sq_s1[0]) + (2*W+1)'(sq_s1[1])
                 + (2*W+1)'(sq_s1[2]) + (2*W+1)'(sq_s1[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_s1_reg <= 1'b0;
            vld_s2_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_s1_reg <= in_valid;
            vld_s2_reg <= vld_s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg  <= sum_next;
            side_reg <= side_next;
        end
    end

    // rounded square root
    qnorm_sqrt #(.W(W), .SIDE_W(SIDE_W)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vld_s2_reg),
        .sum       (sum_reg),
        .side_in   (side_reg),
        .out_valid (sq_vld),
        .len       (len_sq),
        .side_out  (side_sq)
    );

    // divider lanes
    generate
        for (i = 0; i < NC; i++)
        begin : g_div
            qnorm_div_lane #(.W(W)) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .in_valid  (sq_vld),
                .mag       (side_sq[i*(W+1) +: W]),
                .neg       (side_sq[i*(W+1) + W]),
                .len       (len_sq),
                .out_valid (dv_vld[i]),
                .unit      (dv_unit[i]),
                .len_out   (dv_len[i])
            );
        end
    endgenerate

    // output register with zero-length pass-through and saturation
    assign zero_next = (dv_len[0] == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_vld[0] & dv_vld[1] & dv_vld[2] & dv_vld[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < NC; j++)
            begin
                unit_reg[j] <= zero_next ? '0 : dv_unit[j];
            end
            mag_reg  <= dv_len[0][W] ? '1 : dv_len[0][W-1:0];
            zero_reg <= zero_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign unit_w      = unit_reg[0];
    assign unit_x      = unit_reg[1];
    assign unit_y      = unit_reg[2];
    assign unit_z      = unit_reg[3];
    assign magnitude   = mag_reg;
    assign zero_length = zero_reg;

    // checks
    `QN_ASSERT_IMP(a_zero_out, clk, rst_n, out_valid && zero_length,
        magnitude == '0 && unit_w == '0 && unit_x == '0)
    `QN_ASSERT_IMP(a_nonzero_mag, clk, rst_n, out_valid && !zero_length, magnitude != '0)
    `QN_ASSERT_IMP(a_unit_range, clk, rst_n, out_valid && !zero_length,
        $signed(unit_w) <= $signed((W-1)'(1 << F))
        && $signed(unit_w) >= -$signed((W-1)'(1 << F)))
    `QN_ASSERT_NEXT(a_hold, clk, rst_n, in_stall, out_valid)

endmodule

/* hw/rtl/qnorm_square.sv */
module qnorm_square #(
    parameter int W = qnorm_pkg::COMP_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [W-1:0] comp,
    output logic [W-1:0]        mag,
    output logic                neg,
    output logic [2*W-2:0]      sq
);

    logic [W-1:0]   mag_next;
    logic [2*W-1:0] prod;
    logic [W-1:0]   mag_reg;
    logic           neg_reg;
    logic [2*W-2:0] sq_reg;

    // magnitude: the most negative code maps to 2^(W-1) as unsigned
    always_comb
    begin
        mag_next = comp[W-1] ? (~comp + W'(1)) : comp;
        prod     = mag_next * mag_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next;
            neg_reg <= comp[W-1];
            sq_reg  <= prod[2*W-2:0];
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg;
    assign sq  = sq_reg;

endmodule

/* hw/rtl/qnorm_sqrt.sv */
module qnorm_sqrt #(
    parameter int W      = qnorm_pkg::COMP_WIDTH_DEF,
    parameter int SIDE_W = 4 * (qnorm_pkg::COMP_WIDTH_DEF + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*W:0]      sum,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [W:0]        len,
    output logic [SIDE_W-1:0] side_out
);

    localparam int N  = W + 1;
    localparam int RW = 2 * N;
    localparam int MW = N + 3;

    logic [RW-1:0]     rad_reg  [N];
    logic [MW-1:0]     rem_reg  [N];
    logic [N-1:0]      root_reg [N];
    logic [SIDE_W-1:0] side_reg [N];
    logic              vld_reg  [N];

    logic [N-1:0]      len_reg;
    logic [SIDE_W-1:0] side_o_reg;
    logic              vld_o_reg;
    logic [N-1:0]      len_next;

    // one root bit per stage, restoring method
    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic [RW-1:0]     rad_src;
            logic [MW-1:0]     rem_src;
            logic [N-1:0]      root_src;
            logic [SIDE_W-1:0] side_src;
            logic              vld_src;
            logic [MW-1:0]     rem_sh;
            logic [MW-1:0]     trial;
            logic              ge;

            if (k == 0)
            begin : g_first
                assign rad_src  = {1'b0, sum};
                assign rem_src  = '0;
                assign root_src = '0;
                assign side_src = side_in;
                assign vld_src  = in_valid;
            end
            else
            begin : g_rest
                assign rad_src  = rad_reg[k-1];
                assign rem_src  = rem_reg[k-1];
                assign root_src = root_reg[k-1];
                assign side_src = side_reg[k-1];
                assign vld_src  = vld_reg[k-1];
            end

            always_comb
            begin
                rem_sh = {rem_src[MW-3:0], rad_src[RW-1:RW-2]};
                trial  = {1'b0, root_src, 2'b01};
                ge     = (rem_sh >= trial);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[k]  <= {rad_src[RW-3:0], 2'b00};
                    rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                    root_reg[k] <= {root_src[N-2:0], ge};
                    side_reg[k] <= side_src;
                end
            end
        end
    endgenerate

    // round to nearest: add one when the remainder exceeds the root
    always_comb
    begin
        len_next = root_reg[N-1]
                 + N'(rem_reg[N-1] > MW'(root_reg[N-1]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_o_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_o_reg <= vld_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg    <= len_next;
            side_o_reg <= side_reg[N-1];
        end
    end

    assign out_valid = vld_o_reg;
    assign len       = len_reg;
    assign side_out  = side_o_reg;

endmodule

/* hw/rtl/qnorm_div_lane.sv */
module qnorm_div_lane #(
    parameter int W = qnorm_pkg::COMP_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [W-1:0]        mag,
    input  logic                neg,
    input  logic [W:0]          len,
    output logic                out_valid,
    output logic signed [W-2:0] unit,
    output logic [W:0]          len_out
);

    localparam int F = W - 3;
    localparam int S = F + 1;
    localparam int D = W + F + 2;

    logic [D-1:0] rem_reg [S];
    logic [F:0]   q_reg   [S];
    logic [W:0]   len_reg [S];
    logic         neg_reg [S];
    logic         vld_reg [S];

    logic [W-2:0] q_ext;

    // one quotient bit per stage, most significant first
    genvar k;
    generate
        for (k = 0; k < S; k++)
        begin : g_stage
            localparam int SH = F - k;
            logic [D-1:0] rem_src;
            logic [F:0]   q_src;
            logic [W:0]   len_src;
            logic         neg_src;
            logic         vld_src;
            logic [D-1:0] dsh;
            logic         ge;

            if (k == 0)
            begin : g_first
                assign rem_src = (D'(mag) << F) + D'(len >> 1);
                assign q_src   = '0;
                assign len_src = len;
                assign neg_src = neg;
                assign vld_src = in_valid;
            end
            else
            begin : g_rest
                assign rem_src = rem_reg[k-1];
                assign q_src   = q_reg[k-1];
                assign len_src = len_reg[k-1];
                assign neg_src = neg_reg[k-1];
                assign vld_src = vld_reg[k-1];
            end

            always_comb
            begin
                dsh = D'(len_src) << SH;
                ge  = (rem_src >= dsh);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? (rem_src - dsh) : rem_src;
                    q_reg[k]   <= {q_src[F-1:0], ge};
                    len_reg[k] <= len_src;
                    neg_reg[k] <= neg_src;
                end
            end
        end
    endgenerate

    // apply the sign of the original component
    always_comb
    begin
        q_ext = (W-1)'(q_reg[S-1]);
    end

    assign unit      = neg_reg[S-1] ? (~q_ext + (W-1)'(1)) : q_ext;
    assign out_valid = vld_reg[S-1];
    assign len_out   = len_reg[S-1];

endmodule

/* verif/qnorm_checker.sv */
`timescale 1ns / 1ps

module qnorm_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] comp_w,
    input  logic signed [15:0] comp_x,
    input  logic signed [15:0] comp_y,
    input  logic signed [15:0] comp_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [14:0] unit_w,
    input  logic signed [14:0] unit_x,
    input  logic signed [14:0] unit_y,
    input  logic signed [14:0] unit_z,
    input  logic [15:0]        magnitude,
    input  logic               zero_length,
    output int                 fail_count,
    output int                 pending,
    output int                 seen_count
);
    localparam int FRAC = 13;

    typedef struct packed {
        logic signed [14:0] uw;
        logic signed [14:0] ux;
        logic signed [14:0] uy;
        logic signed [14:0] uz;
        logic [15:0]        mag;
        logic               zl;
    } unit_quat_t;

    unit_quat_t unit_queue[$];

    // bitwise integer square root, floor
    function automatic longint unsigned isqrt_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic unit_quat_t normalise(logic signed [15:0] c[4]);
        unit_quat_t      r;
        longint unsigned m[4];
        longint unsigned sum;
        longint unsigned root;
        longint unsigned len;
        longint unsigned q;
        logic [14:0]     u[4];
        sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            m[i] = c[i] < 0 ? longint'(-int'(c[i])) : longint'(c[i]);
            sum += m[i] * m[i];
        end
        root = isqrt_floor(sum);
        len = (sum - root * root > root) ? root + 1 : root;
        if (len == 0)
        begin
            r = '0;
            r.zl = 1'b1;
            return r;
        end
        for (int i = 0; i < 4; i++)
        begin
            q = ((m[i] << FRAC) + (len >> 1)) / len;
            u[i] = c[i] < 0 ? 15'(-q) : 15'(q);
        end
        r.uw = u[0];
        r.ux = u[1];
        r.uy = u[2];
        r.uz = u[3];
        r.mag = len > 65535 ? 16'hffff : 16'(len);
        r.zl = 1'b0;
        return r;
    endfunction

    // predict on input transfer, compare on output transfer
    always @(posedge clk)
    begin
        logic signed [15:0] c[4];
        unit_quat_t         e;
        if (rst_n && in_valid && !in_stall)
        begin
            c[0] = comp_w;
            c[1] = comp_x;
            c[2] = comp_y;
            c[3] = comp_z;
            unit_queue.push_back(normalise(c));
        end
        if (rst_n && out_valid && !out_stall)
        begin
            seen_count++;
            if (unit_queue.size() == 0)
            begin
                $error("result transfer with nothing expected");
                fail_count++;
            end
            else
            begin
                e = unit_queue.pop_front();
                if (unit_w !== e.uw)
                begin
                    $error("unit_w exp %0d got %0d", e.uw, unit_w);
                    fail_count++;
                end
                if (unit_x !== e.ux)
                begin
                    $error("unit_x exp %0d got %0d", e.ux, unit_x);
                    fail_count++;
                end
                if (unit_y !== e.uy)
                begin
                    $error("unit_y exp %0d got %0d", e.uy, unit_y);
                    fail_count++;
                end
                if (unit_z !== e.uz)
                begin
                    $error("unit_z exp %0d got %0d", e.uz, unit_z);
                    fail_count++;
                end
                if (magnitude !== e.mag)
                begin
                    $error("magnitude exp %0d got %0d", e.mag, magnitude);
                    fail_count++;
                end
                if (zero_length !== e.zl)
                begin
                    $error("zero_length exp %0d got %0d", e.zl, zero_length);
                    fail_count++;
                end
            end
        end
        pending = unit_queue.size();
    end

    initial
    begin
        fail_count = 0;
        seen_count = 0;
    end
endmodule

/* verif/tb_quaternion_normalizer.sv */
`timescale 1ns / 1ps

module tb_quaternion_normalizer;
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] comp_w, comp_x, comp_y, comp_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [14:0] unit_w, unit_x, unit_y, unit_z;
    logic [15:0]        magnitude;
    logic               zero_length;
    int                 fail_count, pending, seen_count;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    bit                 hold_off;

    quaternion_normalizer u_top (.*);

    qnorm_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver stall, random or held off
    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

    // offer one quaternion and wait for its transfer
    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        comp_w <= w;
        comp_x <= x;
        comp_y <= y;
        comp_z <= z;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // random component: mostly full range, some small or edge values
    function automatic logic [15:0] rand_comp();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(16)) - 8);
            3: return 16'($signed($urandom_range(2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] ext[6];
        in_valid = 1'b0;
        comp_w = '0;
        comp_x = '0;
        comp_y = '0;
        comp_z = '0;
        out_stall = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero length, all most negative, extremes, single axes
        ext = '{16'h0000, 16'h8000, 16'h7fff, 16'hffff, 16'h0001, 16'h2000};
        send_quat('0, '0, '0, '0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        for (int i = 0; i < 6; i++)
        begin
            send_quat(ext[i], '0, '0, '0);
            send_quat('0, ext[i], '0, '0);
            send_quat('0, '0, ext[i], '0);
            send_quat('0, '0, '0, ext[i]);
        end
        send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (150) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 60; i++)
                send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        join
        in_valid <= 1'b0;
        // sender pauses until the pipeline drains
        while (pending != 0) @(posedge clk);

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = ph == 0 ? 27 : ph == 1 ? 50 : 0;
            recv_idle_pct = ph == 0 ? 50 : ph == 1 ? 27 : 0;
            for (int i = 0; i < 400; i++)
                send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("covered zero length, saturated length, extremes and %0d results",
                 seen_count);
        $display("under sender and receiver idling and a long output hold-off");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
